FILE: rtl/core/kam_pkg.sv
// ----------------------------------------------------------------------------
// kam_pkg
// Types, codes and fixed-point helpers shared by the Kronecker accumulator.
// ----------------------------------------------------------------------------
package kam_pkg;

	localparam int MAX_DIM    = 64;
	localparam int PROP_MAX   = 8;
	localparam int VALUE_BITS = 32;
	localparam int FRAC_BITS  = 16;

	localparam int IDX_W   = $clog2(MAX_DIM);
	localparam int PIDX_W  = $clog2(PROP_MAX);
	localparam int SIZE_W  = 7;
	localparam int PSIZE_W = 4;
	localparam int CUM_AW  = 1 + 2 * IDX_W;
	localparam int PROP_AW = 2 * PIDX_W;
	localparam int PROD_W  = 2 * VALUE_BITS;

	localparam logic [VALUE_BITS-1:0] FIXED_ONE = VALUE_BITS'(1) << FRAC_BITS;

	localparam logic [1:0] OP_REINIT = 2'd0;
	localparam logic [1:0] OP_LOAD   = 2'd1;
	localparam logic [1:0] OP_AGG    = 2'd2;
	localparam logic [1:0] OP_READ   = 2'd3;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_BIG   = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	typedef struct packed {
		logic [1:0]            opcode;
		logic [5:0]            row;
		logic [5:0]            col;
		logic [VALUE_BITS-1:0] value;
		logic [PSIZE_W-1:0]    prop_size;
	} kam_op_t;

	typedef struct packed {
		logic [VALUE_BITS-1:0] read_value;
		logic [SIZE_W-1:0]     matrix_size;
		logic [1:0]            status;
	} kam_res_t;

	// controller -> datapath
	typedef struct packed {
		logic              pend_load;
		logic              pend_move;
		logic [1:0]        status;
		logic [SIZE_W-1:0] size;
		logic              rd_ok;
		logic              reinit;
		logic              prop_wr;
		logic              agg_done;
		logic              walk;
		logic [PIDX_W-1:0] src;
		logic [PIDX_W-1:0] sink;
		logic [IDX_W-1:0]  yb;
		logic [IDX_W-1:0]  xb;
		logic [IDX_W-1:0]  wrow;
		logic [IDX_W-1:0]  wcol;
	} kam_ctl_t;

	// datapath -> controller
	typedef struct packed {
		logic [SIZE_W-1:0] size;
	} kam_stat_t;

	// drop the fraction bits of a full product, saturate to all ones
	function automatic logic [VALUE_BITS-1:0] sat_trunc(input logic [PROD_W-1:0] p);
		logic [PROD_W-1:0] sh;
		sh = p >> FRAC_BITS;
		if (sh[PROD_W-1:VALUE_BITS] != '0)
			return '1;
		return sh[VALUE_BITS-1:0];
	endfunction

endpackage

FILE: rtl/core/kam_dp.sv
// ----------------------------------------------------------------------------
// kam_dp
// Datapath: ping-pong cumulative memory, property memory, multiply pipeline,
// matrix size and the pending/output result registers.
// ----------------------------------------------------------------------------
module kam_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  kam_pkg::kam_op_t   op,
	input  kam_pkg::kam_ctl_t  ctl,
	output kam_pkg::kam_stat_t stat,
	output kam_pkg::kam_res_t  res
);
	import kam_pkg::*;

	logic [VALUE_BITS-1:0] cum_mem  [2**CUM_AW];
	logic [VALUE_BITS-1:0] prop_mem [2**PROP_AW];

	logic              bank_q;
	logic              one_q;     // live matrix is still the reset [1.0]
	logic [SIZE_W-1:0] size_q;

	logic [CUM_AW-1:0]     cum_raddr;
	logic                  rd_en;
	logic [VALUE_BITS-1:0] cum_rd_s1;
	logic [VALUE_BITS-1:0] prop_rd_s1;
	logic [VALUE_BITS-1:0] mul_b;
	logic                  v_s1, v_s2;
	logic [IDX_W-1:0]      wrow_s1, wcol_s1, wrow_s2, wcol_s2;
	logic [PROD_W-1:0]     prod_s2;

	logic [1:0]        pend_status_q;
	logic [SIZE_W-1:0] pend_size_q;
	logic              pend_rd_q;
	logic              pend_one_q;
	kam_res_t          res_q;

	assign cum_raddr = ctl.walk ? {bank_q, ctl.yb, ctl.xb} : {bank_q, op.row, op.col};
	assign rd_en     = ctl.walk || ctl.rd_ok;
	assign mul_b     = one_q ? FIXED_ONE : cum_rd_s1;

	// new matrix is built in the idle bank, then the banks swap
	always_ff @(posedge clk) begin
		if (rd_en)
			cum_rd_s1 <= cum_mem[cum_raddr];
		if (v_s2)
			cum_mem[{~bank_q, wrow_s2, wcol_s2}] <= sat_trunc(prod_s2);
	end

	always_ff @(posedge clk) begin
		if (ctl.prop_wr)
			prop_mem[{op.row[PIDX_W-1:0], op.col[PIDX_W-1:0]}] <= op.value;
		if (ctl.walk)
			prop_rd_s1 <= prop_mem[{ctl.src, ctl.sink}];
	end

	always_ff @(posedge clk) begin
		wrow_s1 <= ctl.wrow;
		wcol_s1 <= ctl.wcol;
		wrow_s2 <= wrow_s1;
		wcol_s2 <= wcol_s1;
		prod_s2 <= PROD_W'(prop_rd_s1) * PROD_W'(mul_b);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= ctl.walk;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_q <= 1'b0;
			one_q  <= 1'b1;
			size_q <= SIZE_W'(1);
		end else if (ctl.reinit) begin
			one_q  <= 1'b1;
			size_q <= SIZE_W'(1);
		end else if (ctl.agg_done) begin
			bank_q <= ~bank_q;
			one_q  <= 1'b0;
			size_q <= ctl.size;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.pend_load) begin
			pend_status_q <= ctl.status;
			pend_size_q   <= ctl.size;
			pend_rd_q     <= ctl.rd_ok;
			pend_one_q    <= one_q;
		end
		if (ctl.pend_move) begin
			res_q.read_value  <= pend_rd_q ? (pend_one_q ? FIXED_ONE : cum_rd_s1) : '0;
			res_q.matrix_size <= pend_size_q;
			res_q.status      <= pend_status_q;
		end
	end

	assign stat.size = size_q;
	assign res       = res_q;

endmodule

FILE: rtl/core/kam_ctrl.sv
// ----------------------------------------------------------------------------
// kam_ctrl
// Controller: opcode decode, range checks, aggregate walk sequencer and the
// pending/output beat handshake.
// ----------------------------------------------------------------------------
module kam_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               op_valid,
	output logic               op_ready,
	input  kam_pkg::kam_op_t   op,
	output logic               res_valid,
	input  logic               res_ready,
	input  kam_pkg::kam_stat_t stat,
	output kam_pkg::kam_ctl_t  ctl
);
	import kam_pkg::*;

	localparam int NW = PSIZE_W + SIZE_W;

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_WALK   = 2'd1;
	localparam logic [1:0] S_DRAIN1 = 2'd2;
	localparam logic [1:0] S_DRAIN2 = 2'd3;

	logic [1:0] state_q, state_d;
	logic       pend_valid_q, res_valid_q;
	logic       out_free, pend_move, take, start_agg;

	logic [PSIZE_W-1:0] p_q;
	logic [SIZE_W-1:0]  m_q, n_q;
	logic [PIDX_W-1:0]  src_q, sink_q;
	logic [IDX_W-1:0]   yb_q, xb_q, rbase_q, cbase_q;
	logic [IDX_W-1:0]   m_last;
	logic [PSIZE_W-1:0] p_last;
	logic               xb_end, yb_end, sink_end, src_end, walk_last;

	logic [NW-1:0] n_full;
	logic          psize_bad, n_big, load_ok, read_ok;

	assign out_free  = !res_valid_q || res_ready;
	assign pend_move = pend_valid_q && out_free;
	assign op_ready  = (state_q == S_IDLE) && (!pend_valid_q || out_free);
	assign take      = op_valid && op_ready;
	assign res_valid = res_valid_q;

	assign n_full    = NW'(op.prop_size) * NW'(stat.size);
	assign psize_bad = (op.prop_size == '0) || (op.prop_size > PSIZE_W'(PROP_MAX));
	assign n_big     = n_full > NW'(MAX_DIM);
	assign load_ok   = (op.row < 6'(PROP_MAX)) && (op.col < 6'(PROP_MAX));
	assign read_ok   = ({1'b0, op.row} < stat.size) && ({1'b0, op.col} < stat.size);
	assign start_agg = take && (op.opcode == OP_AGG) && !psize_bad && !n_big;

	assign m_last    = IDX_W'(m_q - SIZE_W'(1));
	assign p_last    = p_q - PSIZE_W'(1);
	assign xb_end    = xb_q == m_last;
	assign yb_end    = yb_q == m_last;
	assign sink_end  = {1'b0, sink_q} == p_last;
	assign src_end   = {1'b0, src_q} == p_last;
	assign walk_last = xb_end && yb_end && sink_end && src_end;

	always_comb begin
		ctl           = '0;
		ctl.pend_move = pend_move;
		ctl.size      = stat.size;
		ctl.status    = ST_OK;
		ctl.walk      = state_q == S_WALK;
		ctl.src       = src_q;
		ctl.sink      = sink_q;
		ctl.yb        = yb_q;
		ctl.xb        = xb_q;
		ctl.wrow      = rbase_q + yb_q;
		ctl.wcol      = cbase_q + xb_q;
		if (take) begin
			unique case (op.opcode)
				OP_REINIT: begin
					ctl.pend_load = 1'b1;
					ctl.reinit    = 1'b1;
					ctl.size      = SIZE_W'(1);
				end
				OP_LOAD: begin
					ctl.pend_load = 1'b1;
					if (load_ok)
						ctl.prop_wr = 1'b1;
					else
						ctl.status = ST_RANGE;
				end
				OP_AGG: begin
					// accepted aggregate reports after the walk
					if (psize_bad) begin
						ctl.pend_load = 1'b1;
						ctl.status    = ST_RANGE;
					end else if (n_big) begin
						ctl.pend_load = 1'b1;
						ctl.status    = ST_BIG;
					end
				end
				OP_READ: begin
					ctl.pend_load = 1'b1;
					if (read_ok)
						ctl.rd_ok = 1'b1;
					else
						ctl.status = ST_RANGE;
				end
				default: ;
			endcase
		end
		if (state_q == S_DRAIN2) begin
			ctl.pend_load = 1'b1;
			ctl.agg_done  = 1'b1;
			ctl.size      = n_q;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:   if (start_agg) state_d = S_WALK;
			S_WALK:   if (walk_last) state_d = S_DRAIN1;
			S_DRAIN1: state_d = S_DRAIN2;
			S_DRAIN2: state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			pend_valid_q <= 1'b0;
			res_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.pend_load)
				pend_valid_q <= 1'b1;
			else if (pend_move)
				pend_valid_q <= 1'b0;
			if (pend_move)
				res_valid_q <= 1'b1;
			else if (res_ready)
				res_valid_q <= 1'b0;
		end
	end

	// walk order: xb fastest, then yb, sink, src
	always_ff @(posedge clk) begin
		if (start_agg) begin
			p_q     <= op.prop_size;
			m_q     <= stat.size;
			n_q     <= SIZE_W'(n_full);
			src_q   <= '0;
			sink_q  <= '0;
			yb_q    <= '0;
			xb_q    <= '0;
			rbase_q <= '0;
			cbase_q <= '0;
		end else if (state_q == S_WALK) begin
			if (!xb_end) begin
				xb_q <= xb_q + IDX_W'(1);
			end else begin
				xb_q <= '0;
				if (!yb_end) begin
					yb_q <= yb_q + IDX_W'(1);
				end else begin
					yb_q <= '0;
					if (!sink_end) begin
						sink_q  <= sink_q + PIDX_W'(1);
						rbase_q <= rbase_q + IDX_W'(m_q);
					end else begin
						sink_q  <= '0;
						rbase_q <= '0;
						src_q   <= src_q + PIDX_W'(1);
						cbase_q <= cbase_q + IDX_W'(m_q);
					end
				end
			end
		end
	end

	a_pend_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.pend_load |-> (!pend_valid_q || pend_move))
		else $error("pending result overwritten");

	a_walk_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK) |-> (({1'b0, xb_q} < m_q) && ({1'b0, yb_q} < m_q) &&
		({1'b0, src_q} < p_q) && ({1'b0, sink_q} < p_q)))
		else $error("walk index out of range");

	a_drain_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DRAIN2) |-> (!pend_valid_q && !op_ready))
		else $error("pending slot busy at end of aggregate");

	a_walk_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q == S_WALK) |-> $past(take))
		else $error("walk started without an accepted beat");

	a_res_from_pend: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(pend_valid_q))
		else $error("result shown without a pending result");

endmodule

FILE: rtl/core/kronecker_accumulate_matrix_top.sv
// ----------------------------------------------------------------------------
// kronecker_accumulate_matrix_top
// Cumulative Q16.16 scaling matrix grown by Kronecker products.
// ----------------------------------------------------------------------------
// Each op beat gives exactly one res beat. Reinitialize, property load and
// cumulative read take one beat per cycle unless the result path stalls. An
// accepted aggregate walks every element of the new matrix through one
// multiplier fed by the single read port of the cumulative memory; it holds
// op_ready low through the walk and drain states. The cumulative matrix
// lives in two 4096 x 32 banks that swap after each aggregate; the property
// matrix in a 64 x 32 memory. No clearing pass follows reset. Products drop
// the 16 fraction bits and saturate to all ones. Refused operations change
// nothing and report status 1 (too large) or 2 (index out of range).
// ----------------------------------------------------------------------------
module kronecker_accumulate_matrix_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              op_valid,
	output logic              op_ready,
	input  kam_pkg::kam_op_t  op,
	output logic              res_valid,
	input  logic              res_ready,
	output kam_pkg::kam_res_t res
);
	import kam_pkg::*;

	kam_ctl_t  ctl;
	kam_stat_t stat;

	kam_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.op_valid  (op_valid),
		.op_ready  (op_ready),
		.op        (op),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.stat      (stat),
		.ctl       (ctl)
	);

	kam_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (op),
		.ctl    (ctl),
		.stat   (stat),
		.res    (res)
	);

endmodule

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Checks the Kronecker accumulator beat by beat against a local predictor.
// Directed ops cover the index and size refusals, saturation and the largest
// matrix; random sequences then load property blocks, aggregate and read back
// while both channels idle and stall in several patterns.
// ----------------------------------------------------------------------------
module tb_top;
	import kam_pkg::*;

	class kam_scoreboard;
		logic [VALUE_BITS-1:0] cum_mem [MAX_DIM*MAX_DIM];
		logic [VALUE_BITS-1:0] work_mem [MAX_DIM*MAX_DIM];
		logic [VALUE_BITS-1:0] prop_mem [PROP_MAX*PROP_MAX];
		bit                    prop_set [PROP_MAX*PROP_MAX];
		int unsigned           cur_size;
		kam_res_t              expected_q [$];
		int                    errors;

		function new();
			foreach (cum_mem[i]) cum_mem[i] = '0;
			foreach (prop_mem[i]) begin
				prop_mem[i] = '0;
				prop_set[i] = 1'b0;
			end
			cum_mem[0] = FIXED_ONE;
			cur_size = 1;
			errors = 0;
		endfunction

		// truncating, saturating unsigned fixed-point product
		function logic [VALUE_BITS-1:0] mul_q16(logic [VALUE_BITS-1:0] a,
				logic [VALUE_BITS-1:0] b);
			logic [2*VALUE_BITS-1:0] full;
			full = {{VALUE_BITS{1'b0}}, a} * {{VALUE_BITS{1'b0}}, b};
			if ((full >> (VALUE_BITS + FRAC_BITS)) != '0)
				return '1;
			return full[FRAC_BITS +: VALUE_BITS];
		endfunction

		// C <= kron(P^T, C)
		function void grow_cumulative(int unsigned p);
			int unsigned m;
			int unsigned n;
			logic [VALUE_BITS-1:0] pv;
			m = cur_size;
			n = p * m;
			for (int unsigned src = 0; src < p; src++)
				for (int unsigned sink = 0; sink < p; sink++) begin
					pv = prop_mem[src*PROP_MAX + sink];
					for (int unsigned yb = 0; yb < m; yb++)
						for (int unsigned xb = 0; xb < m; xb++)
							work_mem[(sink*m + yb)*MAX_DIM + src*m + xb] =
								mul_q16(pv, cum_mem[yb*MAX_DIM + xb]);
				end
			for (int unsigned r = 0; r < n; r++)
				for (int unsigned c = 0; c < n; c++)
					cum_mem[r*MAX_DIM + c] = work_mem[r*MAX_DIM + c];
			cur_size = n;
		endfunction

		function void note_op(kam_op_t o);
			kam_res_t e;
			int unsigned p;
			e = '0;
			e.status = ST_OK;
			case (o.opcode)
				OP_REINIT: begin
					cur_size = 1;
					cum_mem[0] = FIXED_ONE;
				end
				OP_LOAD: begin
					if (o.row >= PROP_MAX || o.col >= PROP_MAX) begin
						e.status = ST_RANGE;
					end else begin
						prop_mem[o.row*PROP_MAX + o.col] = o.value;
						prop_set[o.row*PROP_MAX + o.col] = 1'b1;
					end
				end
				OP_AGG: begin
					p = 32'(o.prop_size);
					if (p == 0 || p > PROP_MAX)
						e.status = ST_RANGE;
					else if (p * cur_size > MAX_DIM)
						e.status = ST_BIG;
					else
						grow_cumulative(p);
				end
				default: begin
					if (o.row >= cur_size || o.col >= cur_size)
						e.status = ST_RANGE;
					else
						e.read_value = cum_mem[o.row*MAX_DIM + o.col];
				end
			endcase
			e.matrix_size = SIZE_W'(cur_size);
			expected_q = {expected_q, e};
		endfunction

		function void check_res(kam_res_t got);
			kam_res_t want;
			if (expected_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("res beat with nothing expected: value %h size %0d status %0d",
						got.read_value, got.matrix_size, got.status);
				return;
			end
			want = expected_q.pop_front();
			if (got.read_value !== want.read_value || got.matrix_size !== want.matrix_size ||
					got.status !== want.status) begin
				errors++;
				if (errors <= 10)
					$display("res mismatch: exp value %h size %0d status %0d, got value %h size %0d status %0d",
						want.read_value, want.matrix_size, want.status,
						got.read_value, got.matrix_size, got.status);
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	localparam int RANDOM_ITEMS = 1425;
	localparam int PHASES       = 8;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     op_valid = 1'b0;
	logic     op_ready;
	kam_op_t  op = '0;
	logic     res_valid;
	logic     res_ready = 1'b0;
	kam_res_t res;

	int tx_pct = 0;
	int rx_pct = 0;
	int hold_req = 0;
	int hold_left = 0;
	int sent = 0;
	int base;

	kam_scoreboard sb = new();

	kronecker_accumulate_matrix_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.op_valid  (op_valid),
		.op_ready  (op_ready),
		.op        (op),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	always #5 clk = ~clk;

	// both channels observed in one process so a same-edge result sees its op
	always @(posedge clk) begin
		if (arst_n) begin
			if (op_valid && op_ready)
				sb.note_op(op);
			if (res_valid && res_ready)
				sb.check_res(res);
		end
	end

	always @(negedge clk) begin
		if (hold_req > 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			res_ready <= 1'b0;
		end else begin
			res_ready <= ($urandom_range(0, 99) >= rx_pct);
		end
	end

	initial begin
		#300_000_000;
		$display("TB_ERROR");
		$finish;
	end

	function automatic logic [VALUE_BITS-1:0] rand_value();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return $urandom;
			3: return FIXED_ONE;
			default: return $urandom_range(32'h0000_8000, 32'h0002_0000);
		endcase
	endfunction

	function automatic kam_op_t rand_op();
		kam_op_t o;
		o.opcode    = 2'($urandom_range(0, 3));
		o.row       = 6'($urandom);
		o.col       = 6'($urandom);
		o.value     = $urandom;
		o.prop_size = PSIZE_W'($urandom);
		return o;
	endfunction

	// true when an aggregate of size p is refused or reads only loaded elements
	function automatic bit agg_safe(int unsigned p);
		if (p < 1 || p > PROP_MAX || p * sb.cur_size > MAX_DIM)
			return 1'b1;
		for (int r = 0; r < p; r++)
			for (int c = 0; c < p; c++)
				if (!sb.prop_set[r*PROP_MAX + c])
					return 1'b0;
		return 1'b1;
	endfunction

	// entered and left at a falling edge
	task automatic send_op(input kam_op_t o);
		if ($urandom_range(0, 99) < tx_pct) begin
			op_valid <= 1'b0;
			do @(negedge clk); while ($urandom_range(0, 99) < tx_pct);
		end
		op <= o;
		op_valid <= 1'b1;
		do @(posedge clk); while (!op_ready);
		sent++;
		@(negedge clk);
	endtask

	task automatic send_load(input int r, input int c, input logic [VALUE_BITS-1:0] v);
		kam_op_t o;
		o = rand_op();
		o.opcode = OP_LOAD;
		o.row = 6'(r);
		o.col = 6'(c);
		o.value = v;
		send_op(o);
	endtask

	task automatic send_read(input int r, input int c);
		kam_op_t o;
		o = rand_op();
		o.opcode = OP_READ;
		o.row = 6'(r);
		o.col = 6'(c);
		send_op(o);
	endtask

	task automatic send_agg(input int p);
		kam_op_t o;
		o = rand_op();
		o.opcode = OP_AGG;
		o.prop_size = PSIZE_W'(p);
		send_op(o);
	endtask

	task automatic send_reinit();
		kam_op_t o;
		o = rand_op();
		o.opcode = OP_REINIT;
		send_op(o);
	endtask

	// mostly in range, sometimes one index at or beyond the current size
	task automatic send_read_any();
		int m;
		int r;
		int c;
		m = sb.cur_size;
		r = $urandom_range(0, m - 1);
		c = $urandom_range(0, m - 1);
		if (m < 64 && $urandom_range(0, 99) < 15) begin
			if ($urandom_range(0, 1))
				r = $urandom_range(m, 63);
			else
				c = $urandom_range(m, 63);
		end
		send_read(r, c);
	endtask

	// load a fresh property block when needed or by chance, aggregate, read some of the result
	task automatic grow_seq();
		int pmax;
		int p;
		pmax = MAX_DIM / sb.cur_size;
		if (pmax < 2 && $urandom_range(0, 99) < 70)
			send_reinit();
		pmax = MAX_DIM / sb.cur_size;
		if (pmax > PROP_MAX)
			pmax = PROP_MAX;
		p = $urandom_range(1, pmax);
		if (!agg_safe(p) || $urandom_range(0, 99) < 75) begin
			for (int r = 0; r < p; r++)
				for (int c = 0; c < p; c++) begin
					send_load(r, c, rand_value());
					if ($urandom_range(0, 99) < 8)
						send_read_any();
				end
		end
		send_agg(p);
		repeat ($urandom_range(0, 3)) send_read_any();
	endtask

	task automatic noise_op();
		kam_op_t o;
		o = rand_op();
		if (o.opcode == OP_AGG && !agg_safe(32'(o.prop_size)))
			o.opcode = OP_LOAD;
		send_op(o);
	endtask

	task automatic random_step();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 55)
			grow_seq();
		else if (pick < 85)
			repeat ($urandom_range(1, 6)) send_read_any();
		else
			noise_op();
	endtask

	// sender stays quiet until every expected beat has come back
	task automatic wait_idle();
		op_valid <= 1'b0;
		do @(negedge clk); while (sb.pending() != 0);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset state and refusals before anything is loaded
		send_read(0, 0);
		send_read(0, 1);
		send_agg(0);
		send_agg(15);
		send_load(8, 0, '1);
		send_load(0, 63, '1);
		// 2x2 block with the value extremes
		send_load(0, 0, '1);
		send_load(0, 1, '0);
		send_load(1, 0, FIXED_ONE);
		send_load(1, 1, 32'h0001_8000);
		send_agg(2);
		send_read(0, 0);
		send_read(1, 1);
		send_read(1, 0);
		send_read(0, 1);
		// double up to the largest matrix, then one step too far
		repeat (5) send_agg(2);
		send_agg(2);
		send_read(63, 63);
		send_read(0, 63);
		send_reinit();
		send_read(1, 0);
		send_read(0, 0);
		wait_idle();

		base = sent;
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph % 4)
				0: begin tx_pct = 0;  rx_pct = 0;  end
				1: begin tx_pct = 76; rx_pct = 0;  end
				2: begin tx_pct = 0;  rx_pct = 76; end
				default: begin tx_pct = 35; rx_pct = 35; end
			endcase
			if (ph == 0) begin
				// long receiver hold-off against back-to-back beats
				hold_req = 400;
				repeat (60) begin
					if ($urandom_range(0, 1))
						send_read_any();
					else
						send_load($urandom_range(0, 9), $urandom_range(0, 9), rand_value());
				end
			end
			while (sent < base + (ph + 1) * RANDOM_ITEMS / PHASES)
				random_step();
			wait_idle();
		end

		repeat (20) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
